### rtl/rgbhsl_pkg.sv
// Shared widths and constants for the RGB to HSL converter.
`timescale 1ns / 1ps
package rgbhsl_pkg;

    localparam int CHAN_W = 8;
    localparam int HUE_W  = 15;
    localparam int FRAC_W = 16;

    // Divider: numerator, divisor and quotient widths, one quotient bit per stage
    localparam int DIV_NUM_W = 26;
    localparam int DIV_DEN_W = 9;
    localparam int DIV_QUO_W = 16;

    localparam logic [HUE_W-1:0] HUE_FULL_TURN = 15'd23040;

    // Hue offsets premultiplied by 64 (1/64 degree units)
    localparam logic [13:0] OFF_RED   = 14'd0;
    localparam logic [13:0] OFF_GREEN = 14'd7680;
    localparam logic [13:0] OFF_BLUE  = 14'd15360;

    // 60 degrees in 1/64 degree units, and twice the full fraction scale
    localparam logic [11:0] SEXTANT_SCALE = 12'd3840;
    localparam logic [17:0] FRAC_TWICE    = 18'd131070;

endpackage

### rtl/rgbhsl_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module rgbhsl_div (
    input  logic                                clk,
    input  logic                                en,
    input  logic [rgbhsl_pkg::DIV_NUM_W-1:0]    num,
    input  logic [rgbhsl_pkg::DIV_DEN_W-1:0]    den,
    output logic [rgbhsl_pkg::DIV_QUO_W-1:0]    quo
);
    import rgbhsl_pkg::*;

    logic [DIV_NUM_W-1:0] rem_reg [0:DIV_QUO_W-1];
    logic [DIV_DEN_W-1:0] den_reg [0:DIV_QUO_W-1];
    logic [DIV_QUO_W-1:0] quo_reg [0:DIV_QUO_W-1];

    for (genvar k = 0; k < DIV_QUO_W; k++)
    begin : g_stage
        logic [DIV_NUM_W-1:0] rem_in;
        logic [DIV_DEN_W-1:0] den_in;
        logic [DIV_QUO_W-1:0] quo_in;
        logic [DIV_NUM_W-1:0] shifted;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign shifted = DIV_NUM_W'(den_in) << (DIV_QUO_W - 1 - k);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[k] <= den_in;
                if (rem_in >= shifted)
                begin
                    rem_reg[k] <= rem_in - shifted;
                    quo_reg[k] <= quo_in | (DIV_QUO_W'(1) << (DIV_QUO_W - 1 - k));
                end
                else
                begin
                    rem_reg[k] <= rem_in;
                    quo_reg[k] <= quo_in;
                end
            end
        end
    end

    assign quo = quo_reg[DIV_QUO_W-1];

endmodule

### rtl/rgb_to_hsl_converter_top.sv
// Top level of the RGB to HSL converter: front stages, dividers, output register.
//
//  channel | signals                         | direction
//  pixel   | pixel_valid pixel_stall red green blue | in
//  hsl     | hsl_valid hsl_stall hue saturation lightness | out
//
// The pipe is the input register, two arithmetic stages, 16 divider
// stages (one quotient bit each) and the output register. It takes one item
// per cycle while no result is stalled. Reset clears only the valid bits. A
// stalled result freezes the whole pipe; pixel_stall is raised in that cycle.
`timescale 1ns / 1ps
module rgb_to_hsl_converter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  logic [rgbhsl_pkg::CHAN_W-1:0]   red,
    input  logic [rgbhsl_pkg::CHAN_W-1:0]   green,
    input  logic [rgbhsl_pkg::CHAN_W-1:0]   blue,
    output logic                            hsl_valid,
    input  logic                            hsl_stall,
    output logic [rgbhsl_pkg::HUE_W-1:0]    hue,
    output logic [rgbhsl_pkg::FRAC_W-1:0]   saturation,
    output logic [rgbhsl_pkg::FRAC_W-1:0]   lightness
);
    import rgbhsl_pkg::*;

    localparam int NSTAGE = DIV_QUO_W + 4;
    localparam int LDELAY = DIV_QUO_W + 2;

    logic              en;
    logic [NSTAGE-1:0] valid_reg;

    // stage 0
    logic [CHAN_W-1:0] r_reg, g_reg, b_reg;
    // stage 1
    logic [CHAN_W-1:0] mx, mn;
    logic [CHAN_W-1:0] d_reg;
    logic [8:0]        sum_reg;
    logic signed [8:0] diff_next, diff_reg;
    logic [13:0]       off_next, off_reg;
    // stage 2
    logic signed [24:0] t_base, t_wrap;
    logic [DIV_NUM_W-1:0] hue_num_reg, sat_num_reg;
    logic [DIV_DEN_W-1:0] hue_den_reg, sat_den_reg;
    logic [CHAN_W-1:0]    sat_den;
    logic [16:0]          light_full;
    logic [FRAC_W-1:0]    light_reg [0:LDELAY-1];
    // divider outputs and output stage
    logic [DIV_QUO_W-1:0] hue_quo, sat_quo;
    logic [HUE_W-1:0]     hue_reg;
    logic [FRAC_W-1:0]    sat_reg;

    assign en          = !(hsl_valid && hsl_stall);
    assign pixel_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[NSTAGE-2:0], pixel_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= red;
            g_reg <= green;
            b_reg <= blue;
        end
    end

    // Largest channel picks the sextant; later channel wins ties
    always_comb
    begin
        mx = (r_reg > g_reg) ? r_reg : g_reg;
        mx = (mx > b_reg) ? mx : b_reg;
        mn = (r_reg < g_reg) ? r_reg : g_reg;
        mn = (mn < b_reg) ? mn : b_reg;
        if (mx == b_reg)
        begin
            diff_next = $signed({1'b0, r_reg}) - $signed({1'b0, g_reg});
            off_next  = OFF_BLUE;
        end
        else if (mx == g_reg)
        begin
            diff_next = $signed({1'b0, b_reg}) - $signed({1'b0, r_reg});
            off_next  = OFF_GREEN;
        end
        else
        begin
            diff_next = $signed({1'b0, g_reg}) - $signed({1'b0, b_reg});
            off_next  = OFF_RED;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg    <= mx - mn;
            sum_reg  <= {1'b0, mx} + {1'b0, mn};
            diff_reg <= diff_next;
            off_reg  <= off_next;
        end
    end

    // Hue numerator 2t+d over 2d, saturation 2*d*65535+den over 2*den (round half up)
    always_comb
    begin
        t_base = $signed({{16{diff_reg[8]}}, diff_reg}) * $signed(25'(SEXTANT_SCALE))
               + $signed(25'(off_reg) * 25'(d_reg));
        if (t_base < 0)
            t_wrap = t_base + $signed(25'(HUE_FULL_TURN) * 25'(d_reg));
        else
            t_wrap = t_base;
        if (sum_reg < 9'd255)
            sat_den = sum_reg[7:0];
        else
            sat_den = 8'(10'd510 - {1'b0, sum_reg});
        if (sat_den == '0)
            sat_den = 8'd1;
        light_full = 17'((18'(sum_reg) * 18'd257 + 18'd1) >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (d_reg == '0)
            begin
                hue_num_reg <= DIV_NUM_W'(1);
                hue_den_reg <= DIV_DEN_W'(2);
            end
            else
            begin
                hue_num_reg <= DIV_NUM_W'({t_wrap[23:0], 1'b0}) + DIV_NUM_W'(d_reg);
                hue_den_reg <= {d_reg, 1'b0};
            end
            sat_num_reg <= DIV_NUM_W'(d_reg) * DIV_NUM_W'(FRAC_TWICE) + DIV_NUM_W'(sat_den);
            sat_den_reg <= {sat_den, 1'b0};
            light_reg[0] <= light_full[FRAC_W-1:0];
            for (int i = 1; i < LDELAY; i++)
                light_reg[i] <= light_reg[i-1];
        end
    end

    rgbhsl_div u_hue_div (
        .clk (clk),
        .en  (en),
        .num (hue_num_reg),
        .den (hue_den_reg),
        .quo (hue_quo)
    );

    rgbhsl_div u_sat_div (
        .clk (clk),
        .en  (en),
        .num (sat_num_reg),
        .den (sat_den_reg),
        .quo (sat_quo)
    );

    // Wrap a hue that rounds up to a full turn
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (hue_quo >= DIV_QUO_W'(HUE_FULL_TURN))
                hue_reg <= HUE_W'(hue_quo - DIV_QUO_W'(HUE_FULL_TURN));
            else
                hue_reg <= hue_quo[HUE_W-1:0];
            sat_reg <= sat_quo;
        end
    end

    assign hsl_valid  = valid_reg[NSTAGE-1];
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign lightness  = light_reg[LDELAY-1];

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the RGB to HSL converter.
`timescale 1ns / 1ps
module tb_top;
    import rgbhsl_pkg::*;

    localparam int PIPE_DEPTH  = 20;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [FRAC_W-1:0] sat;
        logic [FRAC_W-1:0] light;
    } hsl_t;

    typedef struct {
        logic [7:0] r, g, b;
        logic       known;
        hsl_t       res;
    } pixel_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               pixel_valid = 1'b0;
    logic               pixel_stall;
    logic [CHAN_W-1:0]  red = '0, green = '0, blue = '0;
    logic               hsl_valid;
    logic               hsl_stall = 1'b0;
    logic [HUE_W-1:0]   hue;
    logic [FRAC_W-1:0]  saturation, lightness;

    hsl_t   expected_hsl[$];
    int     error_count = 0;
    int     cycle_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;

    rgb_to_hsl_converter_top DUT (
        .clk(clk), .rst_n(rst_n),
        .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
        .red(red), .green(green), .blue(blue),
        .hsl_valid(hsl_valid), .hsl_stall(hsl_stall),
        .hue(hue), .saturation(saturation), .lightness(lightness)
    );

    always #4 clk = ~clk;

    function automatic hsl_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        longint mx, mn, sum, d, den, num, off, t, h, sq;
        hsl_t   res;
        mx  = (r > g) ? r : g;
        mx  = (mx > b) ? mx : b;
        mn  = (r < g) ? r : g;
        mn  = (mn < b) ? mn : b;
        sum = mx + mn;
        d   = mx - mn;
        res.light = FRAC_W'((sum * 257 + 1) / 2);
        res.sat   = '0;
        res.hue   = '0;
        if (d != 0)
        begin
            den = (sum < 255) ? sum : 510 - sum;
            if (den == 0)
                den = 1;
            sq = (2 * d * 65535 + den) / (2 * den);
            res.sat = (sq > 65535) ? 16'hFFFF : FRAC_W'(sq);
            // blue wins ties over green, green over red
            if (mx == b)
            begin
                num = longint'(r) - longint'(g);
                off = 240;
            end
            else if (mx == g)
            begin
                num = longint'(b) - longint'(r);
                off = 120;
            end
            else
            begin
                num = longint'(g) - longint'(b);
                off = 0;
            end
            t = 3840 * num + off * 64 * d;
            if (t < 0)
                t += 23040 * d;
            h = (2 * t + d) / (2 * d);
            if (h >= 23040)
                h -= 23040;
            res.hue = HUE_W'(h);
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        red <= r;
        green <= g;
        blue <= b;
        expected_hsl.insert(expected_hsl.size(), convert_pixel(r, g, b));
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
    endtask

    // receiver stall and result checking
    always @(posedge clk)
    begin
        hsl_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && hsl_valid && !hsl_stall)
        begin
            if (expected_hsl.size() == 0)
            begin
                $display("MISMATCH unexpected result at cycle %0d", cycle_count);
                error_count++;
            end
            else
            begin
                want = expected_hsl.pop_front();
                if (hue !== want.hue)
                    report_mismatch("hue", hue, want.hue);
                if (saturation !== want.sat)
                    report_mismatch("saturation", saturation, want.sat);
                if (lightness !== want.light)
                    report_mismatch("lightness", lightness, want.light);
            end
        end
        hsl_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    pixel_row_t directed[$];

    task automatic add_row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic known, int h, int s, int l);
        pixel_row_t row;
        row.r = r; row.g = g; row.b = b; row.known = known;
        row.res.hue = HUE_W'(h);
        row.res.sat = FRAC_W'(s);
        row.res.light = FRAC_W'(l);
        directed.insert(directed.size(), row);
    endtask

    initial
    begin
        int idle_mode[4];
        int stall_mode[4];
        logic [7:0] r, g, b;
        int sel;
        idle_mode  = '{0, 66, 0, 17};
        stall_mode = '{0, 0, 66, 17};

        add_row(8'd0,   8'd0,   8'd0,   1, 0,     0,     0);
        add_row(8'd255, 8'd255, 8'd255, 1, 0,     0,     65535);
        add_row(8'd255, 8'd0,   8'd0,   1, 0,     65535, 32768);
        add_row(8'd0,   8'd255, 8'd0,   1, 7680,  65535, 32768);
        add_row(8'd0,   8'd0,   8'd255, 1, 15360, 65535, 32768);
        add_row(8'd128, 8'd128, 8'd128, 0, 0, 0, 0);
        add_row(8'd255, 8'd255, 8'd0,   0, 0, 0, 0);
        add_row(8'd0,   8'd255, 8'd255, 0, 0, 0, 0);
        add_row(8'd255, 8'd0,   8'd255, 0, 0, 0, 0);
        add_row(8'd255, 8'd0,   8'd1,   0, 0, 0, 0);
        add_row(8'd1,   8'd0,   8'd0,   0, 0, 0, 0);
        add_row(8'd254, 8'd255, 8'd255, 0, 0, 0, 0);
        add_row(8'd255, 8'd254, 8'd254, 0, 0, 0, 0);
        add_row(8'd10,  8'd200, 8'd100, 0, 0, 0, 0);
        add_row(8'd170, 8'd85,  8'd0,   0, 0, 0, 0);
        add_row(8'd127, 8'd128, 8'd0,   0, 0, 0, 0);
        add_row(8'd200, 8'd10,  8'd100, 0, 0, 0, 0);
        add_row(8'd255, 8'd1,   8'd0,   0, 0, 0, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // check the known typed-in values against the predictor, then stream all rows
        foreach (directed[i])
        begin
            if (directed[i].known && convert_pixel(directed[i].r, directed[i].g,
                                                   directed[i].b) !== directed[i].res)
                report_mismatch("directed row", i, 0);
            send_pixel(directed[i].r, directed[i].g, directed[i].b);
        end
        pixel_valid <= 1'b0;
        // hold until the pipe drains
        while (expected_hsl.size() != 0)
            @(posedge clk);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = idle_mode[phase];
            recv_stall_pct = stall_mode[phase];
            for (int n = 0; n < 460; n++)
            begin
                r = 8'($urandom_range(255));
                g = 8'($urandom_range(255));
                b = 8'($urandom_range(255));
                sel = $urandom_range(7);
                // bias toward grey, ties and extremes
                if (sel == 0)
                begin
                    g = r;
                    b = r;
                end
                else if (sel == 1)
                    g = r;
                else if (sel == 2)
                    b = g;
                else if (sel == 3)
                    r = b;
                else if (sel == 4)
                begin
                    r = $urandom_range(1) ? 8'd255 : 8'd0;
                    b = $urandom_range(1) ? 8'd255 : 8'd0;
                end
                send_pixel(r, g, b);
            end
            pixel_valid <= 1'b0;
            @(posedge clk);
        end

        while (expected_hsl.size() != 0)
            @(posedge clk);
        recv_stall_pct = 0;
        repeat (PIPE_DEPTH + 5) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
